@@ hw/rtl/vdu_pkg.sv @@
// Shared types, command codes and result kinds for the VDU control stream parser.
// No dependencies; compiled before the interfaces and modules.
package vdu_pkg;

  localparam logic [7:0] CMD_COLOUR  = 8'd17;
  localparam logic [7:0] CMD_MODE    = 8'd22;
  localparam logic [7:0] CMD_DEFCHAR = 8'd23;
  localparam logic [7:0] CMD_CLRWIN  = 8'd26;
  localparam logic [7:0] CMD_ESCAPE  = 8'd27;
  localparam logic [7:0] CMD_TXTWIN  = 8'd28;
  localparam logic [7:0] CMD_ORIGIN  = 8'd29;
  localparam logic [7:0] CMD_HOME    = 8'd30;
  localparam logic [7:0] CMD_CURSOR  = 8'd31;
  localparam logic [7:0] LAST_IGNORED_CTRL = 8'd7;

  localparam logic [2:0] KIND_ABSORBED = 3'd0;
  localparam logic [2:0] KIND_RAW_CHAR = 3'd1;
  localparam logic [2:0] KIND_STYLED   = 3'd2;
  localparam logic [2:0] KIND_CURSOR   = 3'd3;
  localparam logic [2:0] KIND_MODE     = 3'd4;
  localparam logic [2:0] KIND_COLOUR   = 3'd5;
  localparam logic [2:0] KIND_OTHER    = 3'd6;

  typedef struct packed {
    logic [7:0] pending_command;
    logic [3:0] params_expected;
    logic [3:0] params_received;
    logic [7:0] param0;
    logic [7:0] param1;
    logic [3:0] foreground;
    logic [3:0] background;
    logic       mode_is_set;
    logic [7:0] mode_number;
  } vdu_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [1:0] colour_pair;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [7:0] screen_mode;
    logic [3:0] fore_colour;
    logic [3:0] back_colour;
    logic [7:0] command_code;
  } vdu_result_t;

  function automatic logic [3:0] param_count(input logic [7:0] code);
    logic [3:0] n;
    case (code)
      CMD_COLOUR:  n = 4'd1;
      CMD_MODE:    n = 4'd1;
      CMD_DEFCHAR: n = 4'd9;
      CMD_TXTWIN:  n = 4'd4;
      CMD_ORIGIN:  n = 4'd2;
      CMD_CURSOR:  n = 4'd2;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/vdu_byte_if.sv @@
// Request channel that carries one byte of the character output stream.
// Depends on nothing.
interface vdu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ hw/rtl/vdu_event_if.sv @@
// Request channel that carries one decoded result of the VDU stream parser.
// Depends on nothing.
interface vdu_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_code;
  logic [1:0] colour_pair;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic [7:0] screen_mode;
  logic [3:0] fore_colour;
  logic [3:0] back_colour;
  logic [7:0] command_code;

  modport source (output valid, output kind, output char_code, output colour_pair,
                  output cursor_col, output cursor_row, output screen_mode,
                  output fore_colour, output back_colour, output command_code,
                  input ready);
  modport sink (input valid, input kind, input char_code, input colour_pair,
                input cursor_col, input cursor_row, input screen_mode,
                input fore_colour, input back_colour, input command_code,
                output ready);
endinterface

@@ hw/rtl/vdu_control_stream_parser.sv @@
// Top level of the VDU control stream parser: state registers and result register.
// Depends on vdu_pkg, vdu_byte_if, vdu_event_if and vdu_decode.
//
// The stream channel takes one byte of a character output stream per request.
// Every accepted byte yields exactly one request on the events channel that
// tells what the byte did: absorbed, a raw or styled character, a cursor move,
// a mode or colour change, or another command completed.
// Command bytes and their parameter bytes are tracked by a small counter, and
// the first two parameters are kept for the completion.
// A valid result appears in the cycle after acceptance. One byte is accepted
// in every cycle unless the events receiver stalls; the decode of a byte against
// the current state is one short level of logic ahead of the result register.
// When the events receiver stalls, the result register holds its request and
// the stream side still accepts a byte in the same cycle that the held result
// is taken, so a steady stream loses no cycle.
// Reset clears the pending command, sets foreground to one, background and
// mode to zero, and empties the result register.
module vdu_control_stream_parser (
  input logic         clk,
  input logic         rst,
  vdu_byte_if.sink    stream,
  vdu_event_if.source events
);
  import vdu_pkg::*;

  vdu_state_t  state;
  vdu_state_t  state_next;
  vdu_result_t result;
  vdu_result_t result_next;
  logic        result_valid;
  logic        accept;

  assign stream.ready = !result_valid || events.ready;
  assign accept       = stream.valid && stream.ready;

  vdu_decode u_decode (
    .byte_in (stream.byte_in),
    .cur     (state),
    .nxt     (state_next),
    .res     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.pending_command <= '0;
      state.params_expected <= '0;
      state.params_received <= '0;
      state.foreground      <= 4'd1;
      state.background      <= '0;
      state.mode_is_set     <= 1'b0;
      state.mode_number     <= '0;
      result_valid          <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (events.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign events.valid        = result_valid;
  assign events.kind         = result.kind;
  assign events.char_code    = result.char_code;
  assign events.colour_pair  = result.colour_pair;
  assign events.cursor_col   = result.cursor_col;
  assign events.cursor_row   = result.cursor_row;
  assign events.screen_mode  = result.screen_mode;
  assign events.fore_colour  = result.fore_colour;
  assign events.back_colour  = result.back_colour;
  assign events.command_code = result.command_code;

endmodule

@@ hw/rtl/vdu_decode.sv @@
// Combinational decode of one stream byte against the parser state.
// Depends on vdu_pkg for the state and result types and the command codes.
module vdu_decode (
  input  logic [7:0]          byte_in,
  input  vdu_pkg::vdu_state_t cur,
  output vdu_pkg::vdu_state_t nxt,
  output vdu_pkg::vdu_result_t res
);
  import vdu_pkg::*;

  logic [3:0] recv_inc;
  logic [3:0] count;

  assign recv_inc = cur.params_received + 4'd1;
  assign count    = param_count(byte_in);

  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.params_expected != 4'd0) begin
      if (cur.params_received == 4'd0) begin
        nxt.param0 = byte_in;
      end
      if (cur.params_received == 4'd1) begin
        nxt.param1 = byte_in;
      end
      nxt.params_received = recv_inc;
      if (recv_inc >= cur.params_expected) begin
        res.command_code = cur.pending_command;
        unique case (cur.pending_command)
          CMD_COLOUR: begin
            if (nxt.param0[7]) begin
              nxt.background = nxt.param0[3:0];
            end else begin
              nxt.foreground = nxt.param0[3:0];
            end
            res.kind = KIND_COLOUR;
          end
          CMD_MODE: begin
            nxt.mode_number = nxt.param0;
            nxt.mode_is_set = 1'b1;
            res.kind = KIND_MODE;
          end
          CMD_CURSOR: begin
            if (cur.mode_is_set) begin
              res.kind       = KIND_CURSOR;
              res.cursor_col = nxt.param0;
              res.cursor_row = nxt.param1;
            end else begin
              res.kind = KIND_OTHER;
            end
          end
          default: begin
            res.kind = KIND_OTHER;
          end
        endcase
        nxt.params_expected = 4'd0;
        nxt.params_received = 4'd0;
      end
    end else if (count != 4'd0) begin
      nxt.pending_command = byte_in;
      nxt.params_expected = count;
      nxt.params_received = 4'd0;
    end else if (byte_in <= LAST_IGNORED_CTRL || byte_in == CMD_ESCAPE ||
                 byte_in == CMD_HOME) begin
      res.kind = KIND_ABSORBED;
    end else if (byte_in == CMD_CLRWIN) begin
      res.kind         = KIND_OTHER;
      res.command_code = CMD_CLRWIN;
    end else if (!cur.mode_is_set) begin
      res.kind      = KIND_RAW_CHAR;
      res.char_code = byte_in;
    end else begin
      res.kind        = KIND_STYLED;
      res.char_code   = byte_in;
      res.colour_pair = {cur.background[0], ~cur.foreground[0]};
    end
    res.screen_mode = nxt.mode_number;
    res.fore_colour = nxt.foreground;
    res.back_colour = nxt.background;
  end

endmodule
